// ----- hw/rtl/kwsm_pkg.sv -----
// shared types and constants for the k-way sorted merge core
// no dependencies; imported by every module of the block
package kwsm_pkg;

    localparam int IN_VALUE_W = 32;
    localparam int SEL_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic CMD_POP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                         cmd;
        logic [SEL_W-1:0]             queue_sel;
        logic signed [IN_VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [IN_VALUE_W-1:0] out_value;
        logic [SEL_W-1:0]             out_queue;
        logic [STATUS_W-1:0]          status;
    } t_out_item;

    // what the front end decided about a word
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PUSH_DROP,
        OP_POP
    } t_op_kind;

    typedef struct packed {
        t_op_kind                     kind;
        logic [SEL_W-1:0]             sel;
        logic signed [IN_VALUE_W-1:0] value;
    } t_op;

endpackage

// ----- hw/rtl/kwsm_front.sv -----
// front end: accepts input words, classifies them and holds them in a two-entry queue
// depends on kwsm_pkg
module kwsm_front
    import kwsm_pkg::*;
#(
    parameter int NUM_QUEUES = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_op_valid,
    input  logic     i_op_ready,
    output t_op      o_op
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_op        w_op;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_op.sel   = i_in_item.queue_sel;
        w_op.value = i_in_item.push_value;
        if (i_in_item.cmd == CMD_POP) begin
            w_op.kind = OP_POP;
        end else if (int'(i_in_item.queue_sel) < NUM_QUEUES) begin
            w_op.kind = OP_PUSH;
        end else begin
            w_op.kind = OP_PUSH_DROP;
        end
    end

    assign o_in_ready = (r_count != 2'd2);
    assign o_op_valid = (r_count != 2'd0);
    assign o_op       = r_slot[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_op;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("front queue count out of range");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("front queue count missed a word");

    a_pop_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_count == 2'd0 && i_in_item.cmd == CMD_POP)
            |=> (o_op_valid && o_op.kind == OP_POP))
        else $error("pop word misclassified");

endmodule

// ----- hw/rtl/kwsm_back.sv -----
// back end: queue storage, per-queue pointers, head scan and result register
// depends on kwsm_pkg
module kwsm_back
    import kwsm_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    output logic      o_op_ready,
    input  t_op       i_op,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res
);

    localparam int SW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int CW = $clog2(NUM_QUEUES + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_DONE
    } t_state;

    logic signed [SW-1:0] mem [MEM_DEPTH];

    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] r_tail [NUM_QUEUES];
    logic [FW-1:0] r_fill [NUM_QUEUES];

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [CW-1:0]        r_scan, n_scan;
    logic                 r_found, n_found;
    logic [QW-1:0]        r_best_q, n_best_q;
    logic signed [SW-1:0] r_best_v, n_best_v;
    t_out_item            r_res, n_res;
    logic                 r_res_valid, n_res_valid;
    logic                 r_rd_vld;
    logic [QW-1:0]        r_rd_q;
    logic signed [SW-1:0] r_rd_data;

    logic [QW-1:0] w_idx;
    logic [AW-1:0] w_base;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic          w_issue;
    logic          w_push_ok;
    logic          w_wr_en;
    logic          w_take;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // one queue index drives every pointer access in a cycle
    always_comb begin
        case (r_state)
            S_PUSH:  w_idx = QW'(r_op.sel);
            S_SCAN:  w_idx = r_scan[QW-1:0];
            default: w_idx = r_best_q;
        endcase
    end

    assign w_base    = AW'(w_idx) * AW'(QUEUE_DEPTH);
    assign w_rd_addr = w_base + AW'(r_head[w_idx]);
    assign w_wr_addr = w_base + AW'(r_tail[w_idx]);
    assign w_issue   = (r_state == S_SCAN) && (r_scan < CW'(NUM_QUEUES));
    assign w_push_ok = r_fill[w_idx] < FW'(QUEUE_DEPTH);
    assign w_wr_en   = (r_state == S_PUSH) && w_push_ok;
    // strict compare keeps the lowest queue on equal heads
    assign w_take    = r_rd_vld && (!r_found || (r_rd_data < r_best_v));

    assign o_op_ready  = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= SW'(r_op.value);
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_scan      = r_scan;
        n_found     = r_found;
        n_best_q    = r_best_q;
        n_best_v    = r_best_v;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_op_valid && o_op_ready) begin
                    n_op = i_op;
                    case (i_op.kind)
                        OP_POP: begin
                            n_state = S_SCAN;
                            n_scan  = '0;
                            n_found = 1'b0;
                        end
                        OP_PUSH: begin
                            n_state = S_PUSH;
                        end
                        default: begin
                            n_res.out_value = '0;
                            n_res.out_queue = '0;
                            n_res.status    = STATUS_OVERFLOW;
                            n_res_valid     = 1'b1;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                n_res.out_value = '0;
                n_res.out_queue = '0;
                n_res.status    = w_push_ok ? STATUS_OK : STATUS_OVERFLOW;
                n_res_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_scan = r_scan + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
                if (w_take) begin
                    n_found  = 1'b1;
                    n_best_q = r_rd_q;
                    n_best_v = r_rd_data;
                end
            end
            S_DONE: begin
                if (r_found) begin
                    n_res.out_value = IN_VALUE_W'(r_best_v);
                    n_res.out_queue = SEL_W'(r_best_q);
                    n_res.status    = STATUS_OK;
                end else begin
                    n_res.out_value = '0;
                    n_res.out_queue = '0;
                    n_res.status    = STATUS_EMPTY;
                end
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_best_v <= n_best_v;
        r_res    <= n_res;
        r_rd_q   <= w_idx;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_best_q    <= '0;
            r_res_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_found     <= n_found;
            r_best_q    <= n_best_q;
            r_res_valid <= n_res_valid;
            r_rd_vld    <= w_issue && (r_fill[w_idx] != '0);
            if (w_wr_en) begin
                r_tail[w_idx] <= next_slot(r_tail[w_idx]);
                r_fill[w_idx] <= r_fill[w_idx] + 1'b1;
            end else if (r_state == S_DONE && r_found) begin
                r_head[w_idx] <= next_slot(r_head[w_idx]);
                r_fill[w_idx] <= r_fill[w_idx] - 1'b1;
            end
        end
    end

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_res_valid)
        else $error("result pending while an op executes");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_res_valid) && r_res.status == STATUS_EMPTY)
            |-> (r_res.out_value == '0 && r_res.out_queue == '0))
        else $error("empty pop result carries data");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= CW'(NUM_QUEUES))
        else $error("scan index past last queue");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[w_idx] <= FW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

endmodule

// ----- hw/rtl/k_way_sorted_merge_core.sv -----
// k-way sorted merge core: push words append to one of NUM_QUEUES queues, pop words
// remove the smallest head (lowest queue on ties); one result word per input word
// a pop scans the queues, reading one queue head a cycle from the storage memory;
// the back end accepts a new word only in its idle state with the result register
// free or being read, so it finishes each word before it takes the next
// reset (i_rst_n low, synchronous) empties all queues and both channel stages
module k_way_sorted_merge_core
    import kwsm_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_op  w_op;
    logic w_op_valid;
    logic w_op_ready;

    kwsm_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_op_valid (w_op_valid),
        .i_op_ready (w_op_ready),
        .o_op       (w_op)
    );

    kwsm_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .o_op_ready  (w_op_ready),
        .i_op        (w_op),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (o_out_item)
    );

endmodule
